FILE: hw/rtl/cartridge_bank_mapper_irq_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cartridge bank mapper
// Concurrent checks that are compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_MAPPER_IRQ_TOP_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_IRQ_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge out of reset.
`define CBM_ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Antecedent in this cycle implies consequent in the next.
`define CBM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define CBM_ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define CBM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// Types, register map and address decode for the cartridge bank mapper.
// ----------------------------------------------------------------------------
package cbm_pkg;

	// item kinds
	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_TICK  = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	localparam int unsigned NUM_REGS = 24;

	// register file indexes
	localparam logic [4:0] REG_PRG0      = 5'd0;
	localparam logic [4:0] REG_MIRR      = 5'd1;
	localparam logic [4:0] REG_SWAP      = 5'd2;
	localparam logic [4:0] REG_PRG1      = 5'd3;
	localparam logic [4:0] REG_CHR_FIRST = 5'd4;
	localparam logic [4:0] REG_CHR_LAST  = 5'd19;
	localparam logic [4:0] REG_IRQ_LO    = 5'd20;
	localparam logic [4:0] REG_IRQ_HI    = 5'd21;
	localparam logic [4:0] REG_IRQ_CTRL  = 5'd22;
	localparam logic [4:0] REG_IRQ_ACK   = 5'd23;

	// IRQ control bits
	localparam int unsigned CTRL_ENABLE_BIT = 1;
	localparam int unsigned CTRL_CYCLE_BIT  = 2;

	localparam logic [8:0] NUM_PRG_BANKS_RST = 9'd32;
	localparam logic [6:0] PRESCALE_LEN_LONG  = 7'd114;
	localparam logic [6:0] PRESCALE_LEN_SHORT = 7'd113;
	localparam logic [1:0] PRESCALE_LAST_PHASE = 2'd2;
	localparam logic [7:0] IRQ_COUNT_TOP = 8'hFF;
	localparam logic [7:0] PRG_BANK_MASK = 8'h1F;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] addr;
		logic [7:0]  data;
		logic [2:0]  chr_slot;
	} cbm_req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq_line;
		logic [1:0] mirroring;
		logic [7:0] prg_bank_slot0;
		logic [7:0] prg_bank_slot1;
		logic [7:0] prg_bank_slot2;
		logic [7:0] prg_bank_slot3;
		logic [7:0] chr_bank;
	} cbm_rsp_t;

	typedef struct packed {
		logic       hit;
		logic [4:0] idx;
	} cbm_dec_t;

	// Map a CPU address to a register index. Page 8..F, low 12 bits in one of
	// four groups; pages B..F hold four registers each.
	function automatic cbm_dec_t cbm_decode(logic [15:0] addr);
		cbm_dec_t   d;
		logic [3:0] page;
		logic [3:0] page_off;
		logic [1:0] grp;
		logic       grp_ok;
		page     = addr[15:12];
		page_off = page - 4'hB;
		grp      = 2'd0;
		grp_ok   = 1'b1;
		case (addr[11:0])
			12'h000: grp = 2'd0;
			12'h002, 12'h040: grp = 2'd1;
			12'h004, 12'h080: grp = 2'd2;
			12'h006, 12'h0C0: grp = 2'd3;
			default: grp_ok = 1'b0;
		endcase
		d.hit = addr[15] & grp_ok;
		case (page)
			4'h8: d.idx = REG_PRG0;
			4'h9: d.idx = grp[1] ? REG_SWAP : REG_MIRR;
			4'hA: d.idx = REG_PRG1;
			default: d.idx = REG_CHR_FIRST + {page_off[2:0], grp};
		endcase
		return d;
	endfunction

	// prescaler period for a phase: two long, then short
	function automatic logic [6:0] cbm_phase_len(logic [1:0] phase);
		return phase[1] ? PRESCALE_LEN_SHORT : PRESCALE_LEN_LONG;
	endfunction

endpackage

FILE: hw/rtl/cbm_req_if.sv
// ----------------------------------------------------------------------------
// cbm_req_if
// Valid/ready channel carrying one mapper request word.
// ----------------------------------------------------------------------------
interface cbm_req_if import cbm_pkg::*; ();
	logic     valid;
	logic     ready;
	cbm_req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/cbm_rsp_if.sv
// ----------------------------------------------------------------------------
// cbm_rsp_if
// Valid/ready channel carrying one mapper result word.
// ----------------------------------------------------------------------------
interface cbm_rsp_if import cbm_pkg::*; ();
	logic     valid;
	logic     ready;
	cbm_rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/cartridge_bank_mapper_irq_top.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_irq_top
// Bank-switching cartridge mapper with an 8-bit IRQ counter and prescaler.
// ----------------------------------------------------------------------------
//  channel | dir | words                          | handshake
//  --------+-----+--------------------------------+-----------------
//  req     | in  | write / tick / read-back       | valid & ready
//  rsp     | out | read data, IRQ, bank mapping   | valid & ready
//  cfg     | in  | num_prg_banks (9 bits)         | cfg_we, no wait
//
//  One word per cycle sustained while rsp is not stalled; each word passes
//  through the input register into the result register.
//  All mapper state is updated as a word leaves the input register, so the
//  following word already sees it.
//  Reset (arst_n low) clears control and mapper state; bank count goes to 32.
//  A stalled rsp holds both stages; req.ready drops only when both are full.
// ----------------------------------------------------------------------------
`include "cartridge_bank_mapper_irq_top_macros.svh"

module cartridge_bank_mapper_irq_top import cbm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [8:0] cfg_wdata,
	cbm_req_if.sink    req,
	cbm_rsp_if.source  rsp
);

	// ---------------------------------------------------------------- pipeline
	logic     s1_valid_q;
	cbm_req_t item_s1;
	logic     rsp_valid_q;
	cbm_rsp_t rsp_q;
	logic     s1_adv;    // word in s1 moves to the result register

	assign s1_adv    = s1_valid_q && (!rsp_valid_q || rsp.ready);
	assign req.ready = !s1_valid_q || s1_adv;

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	// ------------------------------------------------------------ mapper state
	logic [8:0] num_prg_banks_q;
	logic [7:0] rf_q [NUM_REGS];
	logic [7:0] pb_q [8];
	logic [7:0] reload_q;
	logic [7:0] irq_count_q;
	logic [6:0] pre_count_q;
	logic [1:0] pre_phase_q;
	logic       irq_pending_q;

	logic [7:0] rf_n [NUM_REGS];
	logic [7:0] pb_n [8];
	logic [7:0] reload_n;
	logic [7:0] irq_count_n;
	logic [6:0] pre_count_n;
	logic [1:0] pre_phase_n;
	logic       irq_pending_n;
	cbm_rsp_t   rsp_n;

	// ---------------------------------------------------- next state + result
	always_comb begin
		cbm_dec_t   dec;
		logic [4:0] chr_off;
		logic [7:0] ctrl;
		logic [6:0] pre_inc;
		logic       clk_cnt;
		logic [7:0] second_last;

		rf_n          = rf_q;
		pb_n          = pb_q;
		reload_n      = reload_q;
		irq_count_n   = irq_count_q;
		pre_count_n   = pre_count_q;
		pre_phase_n   = pre_phase_q;
		irq_pending_n = irq_pending_q;
		rsp_n         = '0;

		dec     = cbm_decode(item_s1.addr);
		chr_off = dec.idx - REG_CHR_FIRST;
		ctrl    = rf_q[REG_IRQ_CTRL];
		pre_inc = pre_count_q + 7'd1;
		clk_cnt = 1'b0;

		case (item_s1.func)
			FUNC_WRITE: begin
				if (dec.hit) begin
					rf_n[dec.idx] = item_s1.data;
					if (dec.idx >= REG_CHR_FIRST && dec.idx <= REG_CHR_LAST) begin
						// even register = low nibble, odd = high nibble
						if (dec.idx[0]) begin
							pb_n[chr_off[3:1]][7:4] = item_s1.data[3:0];
						end else begin
							pb_n[chr_off[3:1]][3:0] = item_s1.data[3:0];
						end
					end else if (dec.idx == REG_IRQ_LO) begin
						reload_n[3:0] = item_s1.data[3:0];
					end else if (dec.idx == REG_IRQ_HI) begin
						reload_n[7:4] = item_s1.data[3:0];
					end else if (dec.idx == REG_IRQ_CTRL) begin
						irq_pending_n = 1'b0;
						if (item_s1.data[CTRL_ENABLE_BIT]) begin
							irq_count_n = reload_q;
							pre_count_n = '0;
							pre_phase_n = '0;
						end
					end else if (dec.idx == REG_IRQ_ACK) begin
						// ack: enable-after-ack bit copied into enable
						irq_pending_n = 1'b0;
						rf_n[REG_IRQ_CTRL] = {ctrl[7:2], ctrl[0], ctrl[0]};
					end
				end
			end
			FUNC_TICK: begin
				if (ctrl[CTRL_ENABLE_BIT]) begin
					if (ctrl[CTRL_CYCLE_BIT]) begin
						clk_cnt = 1'b1;
					end else if (pre_inc >= cbm_phase_len(pre_phase_q)) begin
						pre_count_n = '0;
						pre_phase_n = (pre_phase_q == PRESCALE_LAST_PHASE) ? 2'd0
							: (pre_phase_q == 2'd3) ? 2'd1 : pre_phase_q + 2'd1;
						clk_cnt     = 1'b1;
					end else begin
						pre_count_n = pre_inc;
					end
				end
			end
			FUNC_READ: begin
				if (dec.hit) begin
					rsp_n.read_data = rf_q[dec.idx];
				end
			end
			default: begin
			end
		endcase

		if (clk_cnt) begin
			if (irq_count_q == IRQ_COUNT_TOP) begin
				irq_count_n   = reload_q;
				irq_pending_n = 1'b1;
			end else begin
				irq_count_n = irq_count_q + 8'd1;
			end
		end

		// mapping as it stands after this word
		second_last          = 8'(num_prg_banks_q - 9'd2);
		rsp_n.irq_line       = irq_pending_n;
		rsp_n.mirroring      = rf_n[REG_MIRR][1:0];
		rsp_n.prg_bank_slot1 = rf_n[REG_PRG1] & PRG_BANK_MASK;
		rsp_n.prg_bank_slot3 = 8'(num_prg_banks_q - 9'd1);
		rsp_n.chr_bank       = pb_n[item_s1.chr_slot];
		if (rf_n[REG_SWAP][1]) begin
			rsp_n.prg_bank_slot0 = second_last;
			rsp_n.prg_bank_slot2 = rf_n[REG_PRG0] & PRG_BANK_MASK;
		end else begin
			rsp_n.prg_bank_slot0 = rf_n[REG_PRG0] & PRG_BANK_MASK;
			rsp_n.prg_bank_slot2 = second_last;
		end
	end

	// ---------------------------------------------------------------- control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req.ready) begin
				s1_valid_q <= req.valid;
			end
			if (s1_adv) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------ state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_prg_banks_q <= NUM_PRG_BANKS_RST;
			rf_q            <= '{default: '0};
			pb_q            <= '{default: '0};
			reload_q        <= '0;
			irq_count_q     <= '0;
			pre_count_q     <= '0;
			pre_phase_q     <= '0;
			irq_pending_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				num_prg_banks_q <= cfg_wdata;
			end
			if (s1_adv) begin
				rf_q          <= rf_n;
				pb_q          <= pb_n;
				reload_q      <= reload_n;
				irq_count_q   <= irq_count_n;
				pre_count_q   <= pre_count_n;
				pre_phase_q   <= pre_phase_n;
				irq_pending_q <= irq_pending_n;
			end
		end
	end

	// ---------------------------------------------------------------- payload
	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1 <= req.payload;
		end
		if (s1_adv) begin
			rsp_q <= rsp_n;
		end
	end

	// ------------------------------------------------------------- assertions
	`CBM_ASSERT_ALWAYS(a_phase_range, clk, arst_n, pre_phase_q != 2'd3, "prescaler phase out of range")
	`CBM_ASSERT_ALWAYS(a_count_range, clk, arst_n, pre_count_q < PRESCALE_LEN_LONG, "prescaler count overran")
	`CBM_ASSERT_NEXT(a_irq_from_tick, clk, arst_n, !irq_pending_q && !(s1_adv && item_s1.func == FUNC_TICK), !irq_pending_q, "IRQ raised without a tick")
	`CBM_ASSERT_NEXT(a_cnt_disabled, clk, arst_n, s1_adv && item_s1.func == FUNC_TICK && !rf_q[REG_IRQ_CTRL][CTRL_ENABLE_BIT], $stable(irq_count_q) && $stable(pre_count_q), "counter moved while disabled")

endmodule

FILE: sim/cbm_tb_pkg.sv
// ----------------------------------------------------------------------------
// cbm_tb_pkg
// Shadow of the mapper state and the check of each result word against it.
// ----------------------------------------------------------------------------
package cbm_tb_pkg;
	import cbm_pkg::*;

	// func code with no defined operation: the result only reports state
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	// IRQ ack copies this control bit into the enable bit
	localparam int unsigned CTRL_RESTORE_BIT = 0;
	// swap-mode register bit that exchanges slots 0 and 2
	localparam int unsigned SWAP_MODE_BIT = 1;

	class bank_map_tracker;
		logic [8:0] num_banks;
		logic [7:0] regs [NUM_REGS];
		logic [7:0] chr_banks [8];
		logic [7:0] reload;
		logic [7:0] irq_count;
		logic [6:0] pre_count;
		logic [1:0] pre_phase;
		logic       irq_pending;
		cbm_rsp_t   expected_maps [$];
		int unsigned words_in, words_out, errors, irq_rises;

		function new();
			num_banks = NUM_PRG_BANKS_RST;
			foreach (regs[i]) regs[i] = '0;
			foreach (chr_banks[i]) chr_banks[i] = '0;
			reload = '0;
			irq_count = '0;
			pre_count = '0;
			pre_phase = '0;
			irq_pending = 1'b0;
			words_in = 0;
			words_out = 0;
			errors = 0;
			irq_rises = 0;
		endfunction

		function void set_bank_count(logic [8:0] v);
			num_banks = v;
		endfunction

		function int outstanding();
			return expected_maps.size();
		endfunction

		// register index for a CPU address, -1 when nothing answers
		function int reg_index(logic [15:0] a);
			int grp;
			if (a[15] == 1'b0) return -1;
			case (a[11:0])
				12'h000: grp = 0;
				12'h002, 12'h040: grp = 1;
				12'h004, 12'h080: grp = 2;
				12'h006, 12'h0C0: grp = 3;
				default: return -1;
			endcase
			case (a[15:12])
				4'h8: return int'(REG_PRG0);
				4'h9: return (grp < 2) ? int'(REG_MIRR) : int'(REG_SWAP);
				4'hA: return int'(REG_PRG1);
				default: return int'(REG_CHR_FIRST) + (int'(a[15:12]) - 11) * 4 + grp;
			endcase
		endfunction

		function void bump_counter();
			if (irq_count == IRQ_COUNT_TOP) begin
				irq_count = reload;
				if (!irq_pending) irq_rises++;
				irq_pending = 1'b1;
			end else begin
				irq_count = irq_count + 8'd1;
			end
		endfunction

		function void tick();
			logic [6:0] period;
			if (!regs[REG_IRQ_CTRL][CTRL_ENABLE_BIT]) return;
			if (regs[REG_IRQ_CTRL][CTRL_CYCLE_BIT]) begin
				bump_counter();
			end else begin
				period = (pre_phase >= PRESCALE_LAST_PHASE) ? PRESCALE_LEN_SHORT
					: PRESCALE_LEN_LONG;
				pre_count = pre_count + 7'd1;
				if (pre_count >= period) begin
					pre_count = '0;
					pre_phase = (pre_phase >= PRESCALE_LAST_PHASE) ? 2'd0 : pre_phase + 2'd1;
					bump_counter();
				end
			end
		endfunction

		function void write_reg(int r, logic [7:0] d);
			int slot;
			if (r < 0) return;
			regs[5'(r)] = d;
			if (r >= int'(REG_CHR_FIRST) && r <= int'(REG_CHR_LAST)) begin
				slot = (r - int'(REG_CHR_FIRST)) / 2;
				if (r % 2) chr_banks[3'(slot)][7:4] = d[3:0];
				else chr_banks[3'(slot)][3:0] = d[3:0];
			end else if (r == int'(REG_IRQ_LO)) begin
				reload[3:0] = d[3:0];
			end else if (r == int'(REG_IRQ_HI)) begin
				reload[7:4] = d[3:0];
			end else if (r == int'(REG_IRQ_CTRL)) begin
				irq_pending = 1'b0;
				if (d[CTRL_ENABLE_BIT]) begin
					irq_count = reload;
					pre_count = '0;
					pre_phase = '0;
				end
			end else if (r == int'(REG_IRQ_ACK)) begin
				irq_pending = 1'b0;
				regs[REG_IRQ_CTRL][CTRL_ENABLE_BIT] = regs[REG_IRQ_CTRL][CTRL_RESTORE_BIT];
			end
		endfunction

		// apply an accepted request word and queue the mapping it leaves behind
		function void note_word(cbm_req_t w);
			int r;
			cbm_rsp_t e;
			logic [7:0] second_last;
			r = reg_index(w.addr);
			e = '0;
			words_in++;
			case (w.func)
				FUNC_WRITE: write_reg(r, w.data);
				FUNC_TICK: tick();
				FUNC_READ: if (r >= 0) e.read_data = regs[5'(r)];
				default: ;
			endcase
			second_last = num_banks[7:0] - 8'd2;
			e.irq_line = irq_pending;
			e.mirroring = regs[REG_MIRR][1:0];
			if (regs[REG_SWAP][SWAP_MODE_BIT]) begin
				e.prg_bank_slot0 = second_last;
				e.prg_bank_slot2 = regs[REG_PRG0] & PRG_BANK_MASK;
			end else begin
				e.prg_bank_slot0 = regs[REG_PRG0] & PRG_BANK_MASK;
				e.prg_bank_slot2 = second_last;
			end
			e.prg_bank_slot1 = regs[REG_PRG1] & PRG_BANK_MASK;
			e.prg_bank_slot3 = num_banks[7:0] - 8'd1;
			e.chr_bank = chr_banks[w.chr_slot];
			expected_maps.push_back(e);
		endfunction

		function int field_diff(string name, logic [7:0] e, logic [7:0] g);
			if (g === e) return 0;
			$display("%0t mismatch %s: expected %0h, got %0h", $time, name, e, g);
			return 1;
		endfunction

		function void check_word(cbm_rsp_t got);
			cbm_rsp_t e;
			int bad;
			words_out++;
			if (expected_maps.size() == 0) begin
				errors++;
				$display("%0t result word with no request pending: expected none, got %h",
					$time, got);
				return;
			end
			e = expected_maps.pop_front();
			bad = 0;
			bad += field_diff("read_data", e.read_data, got.read_data);
			bad += field_diff("irq_line", 8'(e.irq_line), 8'(got.irq_line));
			bad += field_diff("mirroring", 8'(e.mirroring), 8'(got.mirroring));
			bad += field_diff("prg_bank_slot0", e.prg_bank_slot0, got.prg_bank_slot0);
			bad += field_diff("prg_bank_slot1", e.prg_bank_slot1, got.prg_bank_slot1);
			bad += field_diff("prg_bank_slot2", e.prg_bank_slot2, got.prg_bank_slot2);
			bad += field_diff("prg_bank_slot3", e.prg_bank_slot3, got.prg_bank_slot3);
			bad += field_diff("chr_bank", e.chr_bank, got.chr_bank);
			if (bad != 0) errors++;
		endfunction
	endclass

endpackage

FILE: sim/tb_cartridge_bank_mapper_irq_top.sv
// ----------------------------------------------------------------------------
// tb_cartridge_bank_mapper_irq_top
// Drives register writes, read-backs, CPU ticks and junk words into the mapper, with
// random gaps and result stalls, over a series of bank counts, and checks
// every result word against a cycle-free shadow of the mapper state.
// ----------------------------------------------------------------------------
module tb_cartridge_bank_mapper_irq_top;
	import cbm_pkg::*;
	import cbm_tb_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [8:0] cfg_wdata;

	cbm_req_if req_ch ();
	cbm_rsp_if rsp_ch ();

	cartridge_bank_mapper_irq_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	bank_map_tracker maps = new();

	// idle switches for the two sides, flipped by the stimulus as it goes
	bit tx_idle;
	bit rx_idle;
	int unsigned words_sent;
	int unsigned bank_settings;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Both handshakes are sampled here, before any update of this edge lands.
	// Results are checked first; a request and a result never belong together
	// at the same edge since the block has two register stages.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
				maps.check_word(rsp_ch.payload);
			if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
				maps.note_word(req_ch.payload);
		end
	end

	// Result side: before each word, when rx_idle is set, hold ready low for a random stall.
	initial begin : result_sink
		int stall;
		rsp_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = rx_idle ? $urandom_range(0, 16) : 0;
			if (stall != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (rsp_ch.valid !== 1'b1);
		end
	end

	// Hard stop in case the block hangs.
	initial begin : watchdog
		#800000;
		$display("timeout with %0d result words still pending", maps.outstanding());
		$display("cartridge_bank_mapper_irq_top regression: fail");
		$finish;
	end

	// One request word. Returns at the edge it is taken; the caller then
	// either sends the next word or drops valid in that same step.
	task automatic send_word(input logic [1:0] f, input logic [15:0] a,
			input logic [7:0] d, input logic [2:0] s, input bit counted);
		int gap;
		cbm_req_t w;
		gap = tx_idle ? $urandom_range(0, 16) : 0;
		w.func = f;
		w.addr = a;
		w.data = d;
		w.chr_slot = s;
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.payload <= w;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		if (counted) words_sent++;
	endtask

	// Some decoded address for a register, picking among its aliases.
	function automatic logic [15:0] reg_addr(int r);
		logic [3:0]  page;
		int          grp;
		logic [11:0] low;
		grp = $urandom_range(0, 3);
		if (r == int'(REG_PRG0)) page = 4'h8;
		else if (r == int'(REG_MIRR)) begin
			page = 4'h9;
			grp = grp % 2;
		end else if (r == int'(REG_SWAP)) begin
			page = 4'h9;
			grp = 2 + grp % 2;
		end else if (r == int'(REG_PRG1)) page = 4'hA;
		else begin
			page = 4'hB + 4'((r - int'(REG_CHR_FIRST)) / 4);
			grp = (r - int'(REG_CHR_FIRST)) % 4;
		end
		// groups 1..3 answer at two offsets each
		case (grp)
			0: low = 12'h000;
			1: low = $urandom_range(0, 1) ? 12'h002 : 12'h040;
			2: low = $urandom_range(0, 1) ? 12'h004 : 12'h080;
			default: low = $urandom_range(0, 1) ? 12'h006 : 12'h0C0;
		endcase
		return {page, low};
	endfunction

	task automatic put_reg(input int r, input logic [7:0] d);
		send_word(FUNC_WRITE, reg_addr(r), d, 3'($urandom_range(0, 7)), 1'b1);
	endtask

	task automatic get_reg(input int r);
		send_word(FUNC_READ, reg_addr(r), 8'($urandom), 3'($urandom_range(0, 7)), 1'b1);
	endtask

	task automatic tick_once();
		send_word(FUNC_TICK, 16'($urandom), 8'($urandom), 3'($urandom_range(0, 7)), 1'b1);
	endtask

	// Junk: any func, addresses below the window, with bits 11..8 set, or fully random.
	task automatic noise_word();
		logic [15:0] a;
		a = 16'($urandom);
		case ($urandom_range(0, 2))
			0: a[15] = 1'b0;
			1: begin
				a = reg_addr($urandom_range(0, NUM_REGS - 1));
				a[11:8] = 4'($urandom_range(1, 15));
			end
			default: ;
		endcase
		send_word(2'($urandom_range(0, 3)), a, 8'($urandom), 3'($urandom_range(0, 7)), 1'b0);
	endtask

	// Load a reload value near the top, arm the counter, run the given number
	// of ticks with a few read-backs mixed in, then ack. Prescaler mode gets
	// reload FE or FF so the line rises within two prescaler periods.
	task automatic irq_run(input bit per_cycle, input int ticks);
		logic [7:0] lo;
		logic [7:0] hi;
		logic [7:0] ctrl;
		lo = 8'($urandom);
		hi = 8'($urandom);
		ctrl = 8'($urandom);
		if (!per_cycle) lo[3:1] = 3'b111;
		hi[3:0] = 4'hF;
		ctrl[CTRL_ENABLE_BIT] = 1'b1;
		ctrl[CTRL_CYCLE_BIT] = per_cycle;
		put_reg(int'(REG_IRQ_LO), lo);
		put_reg(int'(REG_IRQ_HI), hi);
		put_reg(int'(REG_IRQ_CTRL), ctrl);
		for (int i = 0; i < ticks; i++) begin
			if ($urandom_range(0, 15) == 0) get_reg($urandom_range(0, NUM_REGS - 1));
			tick_once();
		end
		put_reg(int'(REG_IRQ_ACK), 8'($urandom));
		get_reg(int'(REG_IRQ_CTRL));
	endtask

	task automatic random_word();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 7) tick_once();
		else if (pick < 12) put_reg($urandom_range(0, NUM_REGS - 1), 8'($urandom));
		else if (pick < 16) get_reg($urandom_range(0, NUM_REGS - 1));
		else if (pick < 17) irq_run(1'b1, $urandom_range(1, 40));
		else noise_word();
	endtask

	// Stop sending and wait for every expected word. The first edge lets the
	// monitor note a word taken in this same step.
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (maps.outstanding() != 0) @(posedge clk);
	endtask

	task automatic set_banks(input logic [8:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		maps.set_bank_count(v);
		bank_settings++;
	endtask

	// Short hand-written opening, run at the reset bank count of 32.
	task automatic directed_words();
		send_word(FUNC_READ, 16'hFFFF, 8'h00, 3'd7, 1'b1);    // no register there
		send_word(FUNC_UNUSED, 16'h0000, 8'hFF, 3'd0, 1'b1);  // unused func code
		send_word(FUNC_WRITE, 16'h8000, 8'hFF, 3'd0, 1'b1);   // PRG0, top bits dropped
		send_word(FUNC_WRITE, 16'hA0C0, 8'hFF, 3'd1, 1'b1);   // PRG1 via alias
		send_word(FUNC_WRITE, 16'h9002, 8'h03, 3'd2, 1'b1);   // one-screen B
		send_word(FUNC_WRITE, 16'h9080, 8'h02, 3'd3, 1'b1);   // swap on
		send_word(FUNC_READ, 16'h8040, 8'h00, 3'd4, 1'b1);
		send_word(FUNC_WRITE, 16'hB000, 8'hAB, 3'd0, 1'b1);   // CHR0 low nibble
		send_word(FUNC_WRITE, 16'hB002, 8'hCD, 3'd0, 1'b1);   // CHR0 high nibble
		send_word(FUNC_WRITE, 16'hE0C0, 8'h0F, 3'd7, 1'b1);   // CHR7 high nibble
		send_word(FUNC_READ, 16'h8100, 8'h00, 3'd5, 1'b1);    // bits 11..8 set
		send_word(FUNC_WRITE, 16'h7000, 8'h55, 3'd6, 1'b1);   // below the window
		send_word(FUNC_WRITE, 16'hF000, 8'h0E, 3'd1, 1'b1);   // reload = FE
		send_word(FUNC_WRITE, 16'hF040, 8'h0F, 3'd1, 1'b1);
		send_word(FUNC_WRITE, 16'hF080, 8'h07, 3'd2, 1'b1);   // arm, per cycle
		send_word(FUNC_TICK, 16'h0000, 8'h00, 3'd3, 1'b1);
		send_word(FUNC_TICK, 16'hFFFF, 8'hFF, 3'd3, 1'b1);    // wraps past FF: IRQ
		send_word(FUNC_READ, 16'hF080, 8'h00, 3'd4, 1'b1);
		send_word(FUNC_WRITE, 16'hF0C0, 8'h00, 3'd5, 1'b1);   // ack keeps it armed
		send_word(FUNC_WRITE, 16'hF004, 8'h01, 3'd6, 1'b1);   // disarm, keep restore
		send_word(FUNC_TICK, 16'h1234, 8'h5A, 3'd7, 1'b1);    // no count
		send_word(FUNC_WRITE, 16'hF006, 8'h00, 3'd0, 1'b1);   // ack re-arms
		send_word(FUNC_WRITE, 16'h9000, 8'h00, 3'd1, 1'b1);   // vertical
		send_word(FUNC_WRITE, 16'h9006, 8'h00, 3'd2, 1'b1);   // swap off
	endtask

	initial begin : stimulus
		logic [8:0]  bank_plan [8];
		int unsigned start;
		int unsigned target;
		bit          paused;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.payload <= '0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		words_sent = 0;
		bank_settings = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_words();
		drain();

		// bank counts: both ends of the range, the wrapping ones below 2,
		// and a couple of random values
		bank_plan = '{9'd2, 9'd256, 9'd0, 9'd1, 9'd0, 9'd255, 9'd0, 9'd32};
		bank_plan[2] = 9'($urandom_range(2, 256));
		bank_plan[4] = 9'd0;
		bank_plan[6] = 9'($urandom_range(2, 256));
		bank_plan[3] = 9'd1;

		for (int ph = 0; ph < 8; ph++) begin
			if (ph != 0) drain();
			set_banks(bank_plan[3'(ph)]);
			// phase 1 starts flat out on both sides
			tx_idle = (ph != 1) && ($urandom_range(0, 3) != 0);
			rx_idle = (ph != 1) && ($urandom_range(0, 3) != 0);
			start = words_sent;
			target = (ph % 3 == 0) ? 420 : 80;
			paused = 1'b0;
			// every third phase lets the prescaler run through all its periods
			if (ph % 3 == 0) irq_run(1'b0, $urandom_range(345, 380));
			while (words_sent - start < target) begin
				if (!paused && words_sent - start >= target / 2
						&& (ph == 0 || $urandom_range(0, 2) == 0)) begin
					drain();
					paused = 1'b1;
				end
				if ($urandom_range(0, 47) == 0) begin
					tx_idle = 1'($urandom_range(0, 1));
					rx_idle = 1'($urandom_range(0, 1));
				end
				random_word();
			end
		end

		drain();
		repeat (8) @(posedge clk);

		$display("%0d request words (writes, ticks, read-backs, junk) over %0d bank counts",
			maps.words_in, bank_settings + 1);
		$display("%0d result words checked, %0d interrupt rises, %0d bad words",
			maps.words_out, maps.irq_rises, maps.errors);
		if (maps.outstanding() != 0)
			$display("%0d result words never arrived", maps.outstanding());
		if (maps.errors == 0 && maps.outstanding() == 0) begin
			$display("cartridge_bank_mapper_irq_top regression: pass");
		end else begin
			$display("cartridge_bank_mapper_irq_top regression: fail");
		end
		$finish;
	end

endmodule
